FILE: rtl/core/lppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// shared types and codes for the length-prefixed packet deframer
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int LEN_W = 16;
  localparam int CFG_W = 18;
  localparam logic [CFG_W-1:0] OVERFLOW_LIMIT_RST = 18'd131014;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       flushed;
    logic       dropped;
    logic [6:0] packets_waiting;
  } out_item_t;

endpackage

FILE: rtl/core/lppd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_in_if
// valid/ready channel carrying one request item
// ----------------------------------------------------------------------------
interface lppd_in_if;
  logic               valid;
  logic               ready;
  lppd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lppd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_out_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
interface lppd_out_if;
  logic                valid;
  logic                ready;
  lppd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lppd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_cfg_if
// valid/ready write channel for the overflow limit register
// ----------------------------------------------------------------------------
interface lppd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lppd_pkg::CFG_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lppd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_ram
// generic single-write single-read ram with registered read
// ----------------------------------------------------------------------------
module lppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// store-and-forward deframer for frames led by a 16-bit big-endian length
// ----------------------------------------------------------------------------
// in_*  : request items. req_type 0 pushes in_byte into the byte store;
//         chunk_last on a push walks the stored headers and queues complete
//         frames until a zero-length header, a partial frame or a full queue,
//         then flushes the unframed rest past cfg limit. req_type 1 drains
//         one payload byte with a last-of-packet mark.
// out_* : exactly one result item per request item.
// cfg_* : writes the 18-bit overflow limit; write only while idle.
// Flow: a plain push passes S_PUSH and S_DONE; a drain reads the byte store
//   in S_DRD and gives the byte from S_DOUT, or an empty result from S_DONE.
// A chunk end adds S_HRD0, S_HRD1 and S_HCHK per extracted frame, then
//   stops in S_HRD0 when fewer than three bytes are unframed or the queue
//   is full, else in S_HCHK on the header that stops extraction: header
//   bytes come one per cycle through the single byte store read port.
// A drain that ends a packet holds off the next item through S_NXT0 and
//   S_NXT1 while the next head descriptor is read.
// One item is in work at a time; in_ready rises in S_IDLE when the result
//   register is free or being taken, so a stalled out_ready holds the
//   next item. Reset clears all pointers and counts and empties the queue;
//   store contents need no clearing since only written bytes are ever read.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
  parameter int HEADER_BYTES = 2,
  parameter int STORE_DEPTH  = 262144,
  parameter int QUEUE_DEPTH  = 64
) (
  input  logic clk,
  input  logic rst_n,
  lppd_in_if.sink    in_ch,
  lppd_out_if.source out_ch,
  lppd_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = QW + 1;
  localparam int UW = AW + 1;
  localparam int DW = AW + lppd_pkg::LEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_DRD, S_DOUT, S_HRD0, S_HRD1, S_HCHK, S_DONE, S_NXT0, S_NXT1
  } state_t;

  state_t state_r;
  logic [AW-1:0] wp_r, fsp_r;
  logic [UW-1:0] unf_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] head_r;
  logic [lppd_pkg::LEN_W-1:0] doff_r;
  logic [lppd_pkg::CFG_W-1:0] limit_r;
  lppd_pkg::in_item_t item_r;
  logic drop_r;
  logic [7:0] hi_r;
  logic out_v_r;
  lppd_pkg::out_item_t out_r;
  // head descriptor copy for occupancy
  logic [AW-1:0] hstart_r;

  logic s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [7:0] s_rd;
  logic q_we;
  logic [QW-1:0] q_wa, q_ra;
  logic [DW-1:0] q_wd, q_rd;

  lppd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(item_r.in_byte),
    .raddr(s_ra), .rdata(s_rd)
  );
  lppd_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  logic out_free, acc;
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  logic [AW-1:0] tail, span;
  logic [UW-1:0] used;
  logic full;
  logic [lppd_pkg::LEN_W-1:0] hlen;
  logic [UW:0] total;
  logic [AW-1:0] q_start, q_tailaddr;
  logic [lppd_pkg::LEN_W-1:0] q_len;
  logic [lppd_pkg::LEN_W:0] doff_inc;
  logic last_now, flush_now;

  assign tail = hstart_r + AW'(doff_r);
  assign span = fsp_r - tail;
  assign used = unf_r + ((cnt_r != '0) ? UW'(span) : '0);
  assign full = used >= UW'(STORE_DEPTH - 1);
  assign hlen = {hi_r, s_rd};
  assign total = (UW+1)'(hlen) + (UW+1)'(HEADER_BYTES);
  assign q_start = q_rd[DW-1:lppd_pkg::LEN_W];
  assign q_len = q_rd[lppd_pkg::LEN_W-1:0];
  assign q_tailaddr = q_start + AW'(doff_r);
  assign doff_inc = (lppd_pkg::LEN_W+1)'(doff_r) + 1'b1;
  assign last_now = doff_inc >= (lppd_pkg::LEN_W+1)'(q_len);
  assign flush_now = item_r.chunk_last && (unf_r > UW'(limit_r));

  logic ext_go;
  assign ext_go = (unf_r >= UW'(HEADER_BYTES + 1)) && (cnt_r < CW'(QUEUE_DEPTH));

  always_comb begin
    s_we = (state_r == S_PUSH) && !full;
    s_wa = wp_r;
    s_ra = fsp_r;
    if (state_r == S_DRD) s_ra = q_tailaddr;
    else if (state_r == S_HRD1) s_ra = fsp_r + AW'(1);
    q_ra = head_r;
    q_we = (state_r == S_HCHK) && (hlen != '0) && (total <= (UW+1)'(unf_r));
    q_wa = head_r + QW'(cnt_r);
    q_wd = {fsp_r + AW'(HEADER_BYTES), hlen};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0; fsp_r <= '0; unf_r <= '0; cnt_r <= '0; head_r <= '0;
      doff_r <= '0; limit_r <= lppd_pkg::OVERFLOW_LIMIT_RST; out_v_r <= 1'b0;
      hstart_r <= '0;
    end else begin
      if (cfg_ch.valid) limit_r <= cfg_ch.data;
      if ((state_r == S_DONE) || (state_r == S_DOUT)) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            item_r <= in_ch.data;
            state_r <= (in_ch.data.req_type == lppd_pkg::REQ_PUSH) ? S_PUSH : S_DRD;
          end
        end
        S_PUSH: begin
          drop_r <= full;
          if (!full) begin
            wp_r <= wp_r + AW'(1);
            unf_r <= unf_r + UW'(1);
          end
          state_r <= item_r.chunk_last ? S_HRD0 : S_DONE;
        end
        S_HRD0: begin
          if (ext_go) state_r <= S_HRD1;
          else state_r <= S_DONE;
        end
        S_HRD1: begin
          hi_r <= s_rd;
          state_r <= S_HCHK;
        end
        S_HCHK: begin
          if (q_we) begin
            if (cnt_r == '0) hstart_r <= fsp_r + AW'(HEADER_BYTES);
            cnt_r <= cnt_r + CW'(1);
            fsp_r <= fsp_r + AW'(total);
            unf_r <= unf_r - UW'(total);
            state_r <= S_HRD0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_r <= '{out_valid: 1'b0, out_byte: 8'h00, out_last: 1'b0,
                     flushed: flush_now, dropped: drop_r,
                     packets_waiting: 7'(cnt_r)};
          if (flush_now) begin
            fsp_r <= wp_r;
            unf_r <= '0;
          end
          state_r <= S_IDLE;
        end
        S_DRD: begin
          state_r <= (cnt_r != '0) ? S_DOUT : S_DONE;
          drop_r <= 1'b0;
          item_r.chunk_last <= 1'b0;
        end
        S_DOUT: begin
          out_r <= '{out_valid: 1'b1, out_byte: s_rd, out_last: last_now,
                     flushed: 1'b0, dropped: 1'b0,
                     packets_waiting: last_now ? 7'(cnt_r - CW'(1)) : 7'(cnt_r)};
          if (last_now) begin
            doff_r <= '0;
            head_r <= head_r + QW'(1);
            cnt_r <= cnt_r - CW'(1);
            state_r <= S_NXT0;
          end else begin
            doff_r <= doff_inc[lppd_pkg::LEN_W-1:0];
            state_r <= S_IDLE;
          end
        end
        S_NXT0: begin
          state_r <= S_NXT1;
        end
        S_NXT1: begin
          hstart_r <= q_start;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/tb_length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer
// self-checking bench for the length-prefixed packet deframer. a directed
// table covers empty drains, byte extremes, zero-length headers, split
// frames and flushes, with table results checked on its typed rows. random
// framed byte streams follow under several overflow limits and idle
// patterns. every other result is compared with the predictor
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer;

  localparam int STORE_SZ      = 262144;
  localparam int QUEUE_SZ      = 64;
  localparam int HDR_BYTES     = 2;
  localparam int SETTLE_CYCLES = 3 * QUEUE_SZ + 10;
  localparam int PHASE_ITEMS   = 300;
  localparam int N_PHASES      = 6;
  localparam int N_ROWS        = 22;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       req;
    logic [7:0]                 data_byte;
    logic                       chunk_end;
    bit                         typed;
    lppd_pkg::out_item_t        result;
    logic [lppd_pkg::CFG_W-1:0] limit;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lppd_in_if  in_ch ();
  lppd_out_if out_ch ();
  lppd_cfg_if cfg_ch ();

  length_prefixed_packet_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the deframer state
  bit [7:0]    byte_mem [STORE_SZ];
  int unsigned wr_ptr, frame_ptr, unframed, pkt_count, drain_pos, pkt_head;
  int unsigned pkt_start [QUEUE_SZ];
  int unsigned pkt_len [QUEUE_SZ];
  int unsigned limit_reg;

  lppd_pkg::out_item_t result_q [$];
  int unsigned in_accepts, cfg_accepts;
  int unsigned errors;
  int unsigned in_idle_pct, out_idle_pct;
  bit          drive_typed;
  lppd_pkg::out_item_t drive_result;
  int unsigned n_bytes_out, n_flushes, n_drops, peak_pkts;

  stim_row_t   dir_rows [N_ROWS];
  logic [7:0]  frame_bytes [$];

  function automatic int unsigned store_used();
    int unsigned used;
    int unsigned tail;
    used = unframed;
    if (pkt_count > 0) begin
      tail = (pkt_start[pkt_head] + drain_pos) % STORE_SZ;
      used += (frame_ptr + STORE_SZ - tail) % STORE_SZ;
    end
    return used;
  endfunction

  function automatic lppd_pkg::out_item_t deframe_step(lppd_pkg::in_item_t it);
    lppd_pkg::out_item_t r;
    int unsigned plen;
    int unsigned total;
    int unsigned slot;
    r = '0;
    if (it.req_type == lppd_pkg::REQ_PUSH) begin
      if (store_used() >= STORE_SZ - 1) begin
        r.dropped = 1'b1;
      end else begin
        byte_mem[wr_ptr] = it.in_byte;
        wr_ptr = (wr_ptr + 1) % STORE_SZ;
        unframed++;
      end
      if (it.chunk_last) begin
        while (unframed >= HDR_BYTES + 1 && pkt_count < QUEUE_SZ) begin
          plen = 32'({byte_mem[frame_ptr], byte_mem[(frame_ptr + 1) % STORE_SZ]});
          total = plen + HDR_BYTES;
          if (plen == 0 || total > unframed) break;
          slot = (pkt_head + pkt_count) % QUEUE_SZ;
          pkt_start[slot] = (frame_ptr + HDR_BYTES) % STORE_SZ;
          pkt_len[slot] = plen;
          pkt_count++;
          frame_ptr = (frame_ptr + total) % STORE_SZ;
          unframed -= total;
        end
        if (unframed > limit_reg) begin
          frame_ptr = wr_ptr;
          unframed = 0;
          r.flushed = 1'b1;
        end
      end
    end else if (pkt_count > 0) begin
      r.out_valid = 1'b1;
      r.out_byte = byte_mem[(pkt_start[pkt_head] + drain_pos) % STORE_SZ];
      drain_pos++;
      if (drain_pos >= pkt_len[pkt_head]) begin
        r.out_last = 1'b1;
        drain_pos = 0;
        pkt_head = (pkt_head + 1) % QUEUE_SZ;
        pkt_count--;
      end
    end
    r.packets_waiting = pkt_count[6:0];
    return r;
  endfunction

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // accepts, prediction and checking, all on the rising edge
  always @(posedge clk) begin
    lppd_pkg::out_item_t model_res;
    lppd_pkg::out_item_t want;
    lppd_pkg::out_item_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_reg = 32'(cfg_ch.data);
        cfg_accepts++;
      end
      if (in_ch.valid && in_ch.ready) begin
        model_res = deframe_step(in_ch.data);
        result_q.push_back(drive_typed ? drive_result : model_res);
        if (pkt_count > peak_pkts) peak_pkts = pkt_count;
        in_accepts++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
              got.out_last !== want.out_last || got.flushed !== want.flushed ||
              got.dropped !== want.dropped ||
              got.packets_waiting !== want.packets_waiting) begin
            $display("%0t: mismatch, expected v%b b%h l%b f%b d%b w%0d, actual v%b b%h l%b f%b d%b w%0d",
                     $time, want.out_valid, want.out_byte, want.out_last, want.flushed,
                     want.dropped, want.packets_waiting, got.out_valid, got.out_byte,
                     got.out_last, got.flushed, got.dropped, got.packets_waiting);
            errors++;
          end
          if (got.out_valid === 1'b1) n_bytes_out++;
          if (got.flushed === 1'b1) n_flushes++;
          if (got.dropped === 1'b1) n_drops++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_item(logic req, logic [7:0] data_byte, logic chunk_end);
    lppd_pkg::in_item_t it;
    int unsigned seen;
    it.req_type = req;
    it.in_byte = data_byte;
    it.chunk_last = chunk_end;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    seen = in_accepts;
    do @(negedge clk); while (in_accepts == seen);
  endtask

  task automatic write_limit(logic [lppd_pkg::CFG_W-1:0] value);
    int unsigned seen;
    in_ch.valid <= 1'b0;
    drive_typed = 1'b0;
    @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    seen = cfg_accepts;
    do @(negedge clk); while (cfg_accepts == seen);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    #50ms;
    $display("tb_length_prefixed_packet_deframer: FAIL");
    $finish;
  end

  initial begin
    int unsigned     flen;
    int unsigned     pick;
    int unsigned     limits [N_PHASES];
    int unsigned     drain_pcts [N_PHASES];
    logic [7:0]      b;
    logic            cl;
    int unsigned     n;

    limits = '{64, 8, 300, 0, 1000, 40};
    drain_pcts = '{10, 50, 30, 5, 60, 40};
    dir_rows = '{
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'h3C, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h01, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'hA5, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd1}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h02, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b1, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'hFF, 1'b1, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'hFF, 1'b0, 1'b1, '{1'b1, 8'hA5, 1'b1, 1'b0, 1'b0, 7'd1}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'h00, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'h55, 1'b1, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b1, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h05, 1'b1, 1'b0, '0, '0},
      '{ROW_CFG,  lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b0, '0, 18'd0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h07, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 7'd0}, '0},
      '{ROW_CFG,  lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b0, '0, 18'd262143},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h00, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h01, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_PUSH,  8'h80, 1'b1, 1'b0, '0, '0},
      '{ROW_ITEM, lppd_pkg::REQ_DRAIN, 8'hC3, 1'b0, 1'b1, '{1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 7'd0}, '0}
    };

    wr_ptr = 0; frame_ptr = 0; unframed = 0; pkt_count = 0; drain_pos = 0; pkt_head = 0;
    limit_reg = 32'(lppd_pkg::OVERFLOW_LIMIT_RST);
    in_accepts = 0; cfg_accepts = 0; errors = 0;
    n_bytes_out = 0; n_flushes = 0; n_drops = 0; peak_pkts = 0;
    in_idle_pct = 33; out_idle_pct = 72;
    drive_typed = 1'b0;
    drive_result = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_limit(dir_rows[i].limit);
      end else begin
        drive_typed = dir_rows[i].typed;
        drive_result = dir_rows[i].result;
        send_item(dir_rows[i].req, dir_rows[i].data_byte, dir_rows[i].chunk_end);
      end
    end
    drive_typed = 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_limit(18'(limits[ph]));
      frame_bytes.delete();
      in_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 72 : 0;
      out_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 33 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < drain_pcts[ph]) begin
          send_item(lppd_pkg::REQ_DRAIN, 8'($urandom), 1'($urandom));
        end else begin
          if (frame_bytes.size() == 0) begin
            pick = $urandom_range(99);
            if (pick < 84) flen = $urandom_range(6, 1);
            else if (pick < 88) flen = $urandom_range(40, 7);
            else if (pick < 90) flen = $urandom_range(300, 250);
            else if (pick < 95) flen = 0;
            else flen = 9999;
            if (flen == 9999) begin
              n = $urandom_range(3, 1);
              repeat (n) frame_bytes.push_back(8'($urandom));
            end else begin
              frame_bytes.push_back(8'(flen >> 8));
              frame_bytes.push_back(8'(flen));
              repeat (flen) frame_bytes.push_back(8'($urandom));
            end
          end
          b = frame_bytes.pop_front();
          cl = (frame_bytes.size() == 0 && $urandom_range(1) == 1) ||
               ($urandom_range(7) == 0);
          send_item(lppd_pkg::REQ_PUSH, b, cl);
        end
      end
    end

    // empty the queue, then flush the rest
    in_idle_pct = 0;
    out_idle_pct = 0;
    while (pkt_count > 0) send_item(lppd_pkg::REQ_DRAIN, 8'h00, 1'b0);
    write_limit(18'd0);
    send_item(lppd_pkg::REQ_PUSH, 8'h11, 1'b1);
    send_item(lppd_pkg::REQ_DRAIN, 8'h00, 1'b0);
    in_ch.valid <= 1'b0;

    while (result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d items: %0d payload bytes out, %0d flushes, %0d drops,",
             in_accepts, n_bytes_out, n_flushes, n_drops);
    $display("peak of %0d queued packets, %0d limit writes", peak_pkts, cfg_accepts);
    if (errors == 0) begin
      $display("tb_length_prefixed_packet_deframer: PASS");
    end else begin
      $display("tb_length_prefixed_packet_deframer: FAIL");
    end
    $finish;
  end

endmodule
